FILE: src/mcr_pkg.sv
// Shared types, codes and helpers of the masked color rule mapper.
`default_nettype none

package mcr_pkg;

    localparam int unsigned MAX_RULES = 16;
    localparam int unsigned CNT_W     = $clog2(MAX_RULES + 1);

    localparam logic [1:0] FUNC_PIXEL  = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [2:0] ST_PIXEL    = 3'd0;
    localparam logic [2:0] ST_ADDED    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_REMOVED  = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef logic [MAX_RULES-1:0] rule_vec_t;
    typedef logic [CNT_W-1:0]     rule_cnt_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] match_color;
        logic [31:0] new_color;
        logic [31:0] match_mask;
        logic [31:0] write_mask;
    } mcr_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [2:0] status;
    } mcr_out_t;

    // Lookup results from the rule table for the item in the work stage
    typedef struct packed {
        logic        hit;
        logic [31:0] new_color;
        logic [31:0] write_mask;
        logic        full;
        logic        found;
    } mcr_lookup_t;

    function automatic logic [31:0] pack_argb(input mcr_in_t item);
        pack_argb = {item.alpha, item.red, item.green, item.blue};
    endfunction

endpackage

`default_nettype wire

FILE: src/masked_color_rule_mapper.sv
// Top level of the masked color rule mapper: work stage, result register, rule table.
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   in_data  (mcr_in_t)
//  out       source     out_valid / out_ready out_data (mcr_out_t)
//
// One beat per cycle while out_ready is high; beats pass work stage then result reg.
// Each item sets and reads the rule table in the cycle it leaves the work stage,
// so the next item already sees the updated table.
// Reset empties the table at once (count cleared); no clearing pass.
// A stalled output holds its beat while the work stage still takes one more item.
`default_nettype none

module masked_color_rule_mapper
    import mcr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire mcr_in_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output mcr_out_t     out_data
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    mcr_in_t     s1_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    mcr_out_t    out_reg;
    logic        s1_adv;
    logic        in_take;
    mcr_lookup_t lookup;
    mcr_out_t    result;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_take  = in_valid && in_ready;

    mcr_rule_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (s1_adv),
        .item   (s1_reg),
        .lookup (lookup)
    );

    mcr_result u_result (
        .item   (s1_reg),
        .lookup (lookup),
        .result (result)
    );

    always_comb
    begin
        s1_valid_next = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        priority if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_reg <= in_data;
        if (s1_adv)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("work stage dropped or changed a held item");

    a_rule_zero_color: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_reg.func == FUNC_ADD || s1_reg.func == FUNC_REMOVE))
        |=> (out_data.out_red == 8'd0 && out_data.out_alpha == 8'd0))
        else $error("rule item result carries color");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced item did not reach the result register");

endmodule

`default_nettype wire

FILE: src/mcr_rule_table.sv
// Rule table: entry storage, parallel match and removal search, table update.
`default_nettype none

module mcr_rule_table
    import mcr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        commit,
    input  wire mcr_in_t     item,
    output mcr_lookup_t      lookup
);

    logic [31:0] mc_reg [MAX_RULES];
    logic [31:0] nc_reg [MAX_RULES];
    logic [31:0] mm_reg [MAX_RULES];
    logic [31:0] wm_reg [MAX_RULES];
    logic [31:0] mc_next [MAX_RULES];
    logic [31:0] nc_next [MAX_RULES];
    logic [31:0] mm_next [MAX_RULES];
    logic [31:0] wm_next [MAX_RULES];

    rule_cnt_t   count_reg;
    rule_cnt_t   count_next;

    logic [31:0] pixel;
    rule_vec_t   live;
    rule_vec_t   match;
    rule_vec_t   match_first;
    rule_vec_t   key_hit;
    rule_vec_t   key_first;
    rule_vec_t   shift_mask;
    logic [31:0] sel_nc;
    logic [31:0] sel_wm;
    logic        full;
    logic        found;
    logic        do_add;
    logic        do_remove;

    assign pixel = pack_argb(item);
    assign full  = (count_reg == CNT_W'(MAX_RULES));

    always_comb
    begin
        for (int k = 0; k < MAX_RULES; k++)
        begin
            live[k]    = (CNT_W'(k) < count_reg);
            match[k]   = live[k] && ((pixel & mm_reg[k]) == (mc_reg[k] & mm_reg[k]));
            key_hit[k] = live[k] && (mc_reg[k] == item.match_color);
        end
    end

    // Isolate the lowest set bit: first rule in table order wins
    assign match_first = match & (~match + MAX_RULES'(1));
    assign key_first   = key_hit & (~key_hit + MAX_RULES'(1));
    assign found       = |key_hit;
    // Entries at or above the removed one; zero when the key is absent
    assign shift_mask  = ~(key_first - MAX_RULES'(1));

    always_comb
    begin
        sel_nc = '0;
        sel_wm = '0;
        for (int k = 0; k < MAX_RULES; k++)
        begin
            sel_nc = sel_nc | (nc_reg[k] & {32{match_first[k]}});
            sel_wm = sel_wm | (wm_reg[k] & {32{match_first[k]}});
        end
    end

    assign lookup = '{hit: |match, new_color: sel_nc, write_mask: sel_wm,
                      full: full, found: found};

    assign do_add    = commit && (item.func == FUNC_ADD) && !full;
    assign do_remove = commit && (item.func == FUNC_REMOVE) && found;

    always_comb
    begin
        for (int j = 0; j < MAX_RULES; j++)
        begin
            mc_next[j] = mc_reg[j];
            nc_next[j] = nc_reg[j];
            mm_next[j] = mm_reg[j];
            wm_next[j] = wm_reg[j];
            if (do_add && (CNT_W'(j) == count_reg))
            begin
                mc_next[j] = item.match_color;
                nc_next[j] = item.new_color;
                mm_next[j] = item.match_mask;
                wm_next[j] = item.write_mask;
            end
            else if (do_remove && shift_mask[j] && (j + 1 < MAX_RULES))
            begin
                mc_next[j] = mc_reg[(j + 1) % MAX_RULES];
                nc_next[j] = nc_reg[(j + 1) % MAX_RULES];
                mm_next[j] = mm_reg[(j + 1) % MAX_RULES];
                wm_next[j] = wm_reg[(j + 1) % MAX_RULES];
            end
        end
    end

    always_comb
    begin
        priority if (do_add)
            count_next = count_reg + CNT_W'(1);
        else if (do_remove)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_RULES; j++)
        begin
            mc_reg[j] <= mc_next[j];
            nc_reg[j] <= nc_next[j];
            mm_reg[j] <= mm_next[j];
            wm_reg[j] <= wm_next[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RULES))
        else $error("rule count above capacity");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_add |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("add did not grow the table by one");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        do_remove |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not shrink the table by one");

    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && item.func == FUNC_ADD && full) |=> $stable(count_reg))
        else $error("add on a full table changed the count");

endmodule

`default_nettype wire

FILE: src/mcr_result.sv
// Result former: applies the winning rule's write mask and picks the status code.
`default_nettype none

module mcr_result
    import mcr_pkg::*;
(
    input  wire mcr_in_t     item,
    input  wire mcr_lookup_t lookup,
    output mcr_out_t         result
);

    logic [31:0] pixel;
    logic [31:0] mapped;

    assign pixel  = pack_argb(item);
    assign mapped = lookup.hit
                  ? ((pixel & ~lookup.write_mask) | (lookup.new_color & lookup.write_mask))
                  : pixel;

    always_comb
    begin
        result = '0;
        unique case (item.func)
            FUNC_ADD:
                result.status = lookup.full ? ST_FULL : ST_ADDED;
            FUNC_REMOVE:
                result.status = lookup.found ? ST_REMOVED : ST_NOTFOUND;
            default:
            begin
                result.out_alpha = mapped[31:24];
                result.out_red   = mapped[23:16];
                result.out_green = mapped[15:8];
                result.out_blue  = mapped[7:0];
                result.status    = ST_PIXEL;
            end
        endcase
    end

endmodule

`default_nettype wire
